>>> hw/rtl/gboc_pkg.sv
// Shared types, widths and helper functions for the box clustering core.
// No dependencies; imported by the memory, divider, top level and bench.
package gboc_pkg;

    localparam int COORD_W = 12;
    localparam int CNT_W   = 16;
    localparam int CAP_W   = 9;
    localparam int AREA_W  = 2 * COORD_W;
    localparam int PROD_W  = CAP_W + AREA_W;
    localparam int DVD_W   = COORD_W + CNT_W + 1;
    localparam int DIV_W   = CNT_W + 1;
    localparam int IDX_W   = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd128;
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // configuration register byte addresses
    localparam logic [1:0] REG_CAP = 2'd0;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } t_box;

    typedef struct packed {
        t_box             cov;
        t_box             mean;
        logic [CNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic [IDX_W-1:0]   cluster_index;
        logic               created;
        logic               dropped;
        logic [CNT_W-1:0]   member_count;
        t_box               mean;
    } t_result;

    // intersection of two boxes, empty box when width or height is not positive
    function automatic t_box overlap_of(input t_box a, input t_box b);
        logic [COORD_W:0] x1, y1, x2, y2, ax2, bx2, ay2, by2;
        t_box r;
        x1  = (a.x > b.x) ? {1'b0, a.x} : {1'b0, b.x};
        y1  = (a.y > b.y) ? {1'b0, a.y} : {1'b0, b.y};
        ax2 = {1'b0, a.x} + {1'b0, a.w};
        bx2 = {1'b0, b.x} + {1'b0, b.w};
        ay2 = {1'b0, a.y} + {1'b0, a.h};
        by2 = {1'b0, b.y} + {1'b0, b.h};
        x2  = (ax2 < bx2) ? ax2 : bx2;
        y2  = (ay2 < by2) ? ay2 : by2;
        r   = '0;
        if (x2 > x1 && y2 > y1) begin
            r.x = x1[COORD_W-1:0];
            r.y = y1[COORD_W-1:0];
            r.w = COORD_W'(x2 - x1);
            r.h = COORD_W'(y2 - y1);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/gboc_mem.sv
// Cluster table: one synchronous RAM, one write and one read port, registered read.
// Depends on gboc_pkg for the entry type.
module gboc_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  gboc_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output gboc_pkg::t_entry o_rdata
);
    import gboc_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

>>> hw/rtl/gboc_div.sv
// Restoring divider lane, one quotient bit per cycle, quotient known to fit 12 bits.
// Depends on gboc_pkg for widths.
module gboc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gboc_pkg::DVD_W-1:0]    i_dividend,
    input  logic [gboc_pkg::DIV_W-1:0]    i_divisor,
    output logic [gboc_pkg::COORD_W-1:0]  o_quot,
    output logic                          o_done
);
    import gboc_pkg::*;

    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_div;
    logic [COORD_W-1:0] r_quo;
    logic [3:0]         r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [DIV_W:0]     n_trial;
    logic [DIV_W:0]     n_diff;
    logic               n_ge;

    always_comb begin
        n_trial = {r_rem, r_quo[COORD_W-1]};
        n_diff  = n_trial - {1'b0, r_div};
        n_ge    = (n_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 4'(COORD_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 4'd1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // top bits are already below the divisor
            r_rem <= i_dividend[DVD_W-1:COORD_W];
            r_quo <= i_dividend[COORD_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[DIV_W-1:0] : n_trial[DIV_W-1:0];
            r_quo <= {r_quo[COORD_W-2:0], n_ge};
        end
    end

    assign o_quot = r_quo;
    assign o_done = r_done;

endmodule

>>> hw/rtl/greedy_box_overlap_clustering_core.sv
// Greedy box-overlap clustering core: top level with the sequencer.
// Depends on gboc_pkg, gboc_mem and gboc_div.
//
// Usage notes:
//   Input channel (i_in_valid / o_in_ready) carries one word per box: an
//   operation code plus box x, y, w, h. Output channel (o_out_valid /
//   i_out_ready) returns exactly one result word per input word.
//   Configuration: APB-style write of cap_q8 at byte address 0 while idle.
//   Processing: an add walks the slots in order; each cluster in use passes
//   RAM read, overlap, areas, cap products and compare, and each free slot
//   only the scan state. A join stops at the accepting cluster and goes on
//   through a multiply step, the four parallel divider lanes, a write-back
//   step and a park step before the result is valid. A new cluster or a
//   drop walks every slot; a clear goes straight to the park step.
//   One box is in flight at a time; the core is ready for the next in the
//   cycle after the result is parked in the output register, even while that result waits.
//   Reset empties the table (valid bits only) and sets cap_q8 to 128.
//   If the receiver stalls with a result parked, a finished next result
//   waits in the sequencer until the output register frees.
module greedy_box_overlap_clustering_core #(
    parameter int MAX_CLUSTERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [11:0] i_box_x,
    input  logic [11:0] i_box_y,
    input  logic [11:0] i_box_w,
    input  logic [11:0] i_box_h,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_cluster_index,
    output logic        o_created,
    output logic        o_dropped,
    output logic [15:0] o_member_count,
    output logic [11:0] o_mean_x,
    output logic [11:0] o_mean_y,
    output logic [11:0] o_mean_w,
    output logic [11:0] o_mean_h,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gboc_pkg::*;

    localparam int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam logic [IW:0] K_END = (IW + 1)'(MAX_CLUSTERS);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_OV, S_AREA, S_PROD, S_TEST,
        S_MUL, S_DIV, S_UPD, S_NEW, S_FIN
    } t_state;

    t_state             r_state;
    logic [CAP_W-1:0]   r_cap;
    logic [MAX_CLUSTERS-1:0] r_used;
    t_box               r_box;
    logic [IW:0]        r_k;
    logic               r_free_found;
    logic [IW-1:0]      r_free_slot;
    t_box               r_ov;
    logic [AREA_W-1:0]  r_a_ov, r_a_cov, r_a_b;
    logic [PROD_W-1:0]  r_p_cov, r_p_b;
    t_result            r_pend;
    t_result            r_res;
    logic               r_out_valid;

    t_entry             mem_q;
    t_entry             mem_wdata;
    logic               mem_we;
    logic               mem_re;
    logic [IW-1:0]      k_idx;
    logic [IW-1:0]      mem_waddr;

    logic [COORD_W-1:0] quot [4];
    logic [3:0]         div_done;
    logic [DVD_W-1:0]   dvd  [4];
    logic [DIV_W-1:0]   n_plus1;
    logic [CNT_W-1:0]   n_sat;
    logic               div_start;
    logic [PROD_W-1:0]  a_ov_scaled;
    logic               accept_hit;
    logic [IW+3:0]      idx_wide;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == REG_CAP) ? {{(32 - CAP_W){1'b0}}, r_cap} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    // ---------------- cluster table ----------------
    assign k_idx  = r_k[IW-1:0];
    assign mem_re = (r_state == S_SCAN) && (r_k != K_END) && r_used[k_idx];
    assign mem_we = (r_state == S_UPD) || (r_state == S_NEW);
    assign mem_waddr = (r_state == S_NEW) ? r_free_slot : k_idx;

    gboc_mem #(.DEPTH(MAX_CLUSTERS), .AW(IW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (k_idx),
        .o_rdata (mem_q)
    );

    // ---------------- mean update: multiply, then four divider lanes ----------------
    assign n_plus1   = {1'b0, mem_q.count} + DIV_W'(1);
    assign n_sat     = (mem_q.count == CNT_MAX) ? mem_q.count : mem_q.count + CNT_W'(1);
    assign div_start = (r_state == S_MUL);

    assign dvd[0] = DVD_W'(mem_q.mean.x) * DVD_W'(mem_q.count) + DVD_W'(r_box.x);
    assign dvd[1] = DVD_W'(mem_q.mean.y) * DVD_W'(mem_q.count) + DVD_W'(r_box.y);
    assign dvd[2] = DVD_W'(mem_q.mean.w) * DVD_W'(mem_q.count) + DVD_W'(r_box.w);
    assign dvd[3] = DVD_W'(mem_q.mean.h) * DVD_W'(mem_q.count) + DVD_W'(r_box.h);

    for (genvar g = 0; g < 4; g++) begin : g_div
        gboc_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (div_start),
            .i_dividend (dvd[g]),
            .i_divisor  (n_plus1),
            .o_quot     (quot[g]),
            .o_done     (div_done[g])
        );
    end

    always_comb begin
        mem_wdata = '0;
        if (r_state == S_NEW) begin
            mem_wdata.cov   = r_box;
            mem_wdata.mean  = r_box;
            mem_wdata.count = CNT_W'(1);
        end else begin
            mem_wdata.cov    = r_ov;
            mem_wdata.mean.x = quot[0];
            mem_wdata.mean.y = quot[1];
            mem_wdata.mean.w = quot[2];
            mem_wdata.mean.h = quot[3];
            mem_wdata.count  = n_sat;
        end
    end

    // acceptance test: overlap area * 256 against cap * area
    assign a_ov_scaled = PROD_W'({r_a_ov, 8'b0});
    assign accept_hit  = (a_ov_scaled >= r_p_cov) || (a_ov_scaled >= r_p_b);
    assign idx_wide    = {4'b0, k_idx};

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_out_valid  <= 1'b0;
            r_k          <= '0;
            r_free_found <= 1'b0;
        end else begin
            // S_FIN handles the output register itself
            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_box        <= '{x: i_box_x, y: i_box_y, w: i_box_w, h: i_box_h};
                        r_k          <= '0;
                        r_free_found <= 1'b0;
                        r_pend       <= '0;
                        if (i_operation == OP_CLEAR) begin
                            r_used  <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_k == K_END) begin
                        if (r_free_found) begin
                            r_state <= S_NEW;
                        end else begin
                            r_pend.dropped <= 1'b1;
                            r_state        <= S_FIN;
                        end
                    end else if (r_used[k_idx]) begin
                        r_state <= S_OV;
                    end else begin
                        if (!r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_slot  <= k_idx;
                        end
                        r_k <= r_k + 1'b1;
                    end
                end
                S_OV: begin
                    r_ov    <= overlap_of(mem_q.cov, r_box);
                    r_state <= S_AREA;
                end
                S_AREA: begin
                    r_a_ov  <= r_ov.w * r_ov.h;
                    r_a_cov <= mem_q.cov.w * mem_q.cov.h;
                    r_a_b   <= r_box.w * r_box.h;
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    r_p_cov <= r_cap * r_a_cov;
                    r_p_b   <= r_cap * r_a_b;
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    if (accept_hit) begin
                        r_state <= S_MUL;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (&div_done) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_pend.cluster_index <= idx_wide[3:0];
                    r_pend.member_count  <= n_sat;
                    r_pend.mean          <= mem_wdata.mean;
                    r_state              <= S_FIN;
                end
                S_NEW: begin
                    r_used[r_free_slot]  <= 1'b1;
                    r_pend.cluster_index <= 4'({4'b0, r_free_slot});
                    r_pend.created       <= 1'b1;
                    r_pend.member_count  <= CNT_W'(1);
                    r_pend.mean          <= r_box;
                    r_state              <= S_FIN;
                end
                S_FIN: begin
                    // park the result once the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_res       <= r_pend;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_cluster_index = r_res.cluster_index;
    assign o_created       = r_res.created;
    assign o_dropped       = r_res.dropped;
    assign o_member_count  = r_res.member_count;
    assign o_mean_x        = r_res.mean.x;
    assign o_mean_y        = r_res.mean.y;
    assign o_mean_w        = r_res.mean.w;
    assign o_mean_h        = r_res.mean.h;

endmodule

>>> hw/rtl/gboc_checker.sv
// Port-level checks for the clustering core, bound to the top level.
// Depends only on the top level's ports.
module gboc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  o_cluster_index,
    input logic        o_created,
    input logic        o_dropped,
    input logic [15:0] o_member_count,
    input logic        pready
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_member_count)
            && $stable(o_cluster_index))
        else $error("stalled result word changed");

    a_drop_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dropped |-> o_cluster_index == 4'd0 && !o_created
            && o_member_count == 16'd0)
        else $error("dropped word carries cluster data");

    a_new_cluster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_created |-> o_member_count == 16'd1 && !o_dropped)
        else $error("new cluster word with wrong count");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind greedy_box_overlap_clustering_core gboc_checker u_gboc_checker (.*);

>>> tb/greedy_box_overlap_clustering_core_tb.sv
// Self-checking bench for the greedy box-overlap clustering core: directed
// and random boxes against an in-bench cluster table predictor.
// Depends on gboc_pkg and the greedy_box_overlap_clustering_core RTL.
module greedy_box_overlap_clustering_core_tb;
    import gboc_pkg::*;

    localparam int NUM_SLOTS  = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_operation;
    logic [11:0] i_box_x, i_box_y, i_box_w, i_box_h;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [3:0]  o_cluster_index;
    logic        o_created, o_dropped;
    logic [15:0] o_member_count;
    logic [11:0] o_mean_x, o_mean_y, o_mean_w, o_mean_h;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    greedy_box_overlap_clustering_core #(.MAX_CLUSTERS(NUM_SLOTS)) uut (.*);

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // predicted cluster table and cap register
    bit          slot_used [NUM_SLOTS];
    t_box        slot_meet [NUM_SLOTS];   // running intersection
    t_box        slot_avg  [NUM_SLOTS];   // mean box
    int unsigned slot_cnt  [NUM_SLOTS];
    int unsigned cap_cur;

    t_result pending_words[$];   // expected result words, oldest first
    int      fail_count = 0;
    int      tx_gap_pct;
    int      rx_idle_pct;
    bit      hold_req;           // raised by the backpressure test
    bit      hold_done;
    int      hold_left;
    int      quiet_cycles;

    function automatic t_box box_meet(t_box a, t_box b);
        int x1, y1, x2, y2;
        t_box r;
        x1 = (a.x > b.x) ? a.x : b.x;
        y1 = (a.y > b.y) ? a.y : b.y;
        x2 = (int'(a.x) + a.w < int'(b.x) + b.w) ? int'(a.x) + a.w : int'(b.x) + b.w;
        y2 = (int'(a.y) + a.h < int'(b.y) + b.h) ? int'(a.y) + a.h : int'(b.y) + b.h;
        r = '0;
        if (x2 > x1 && y2 > y1) begin
            r.x = COORD_W'(x1);
            r.y = COORD_W'(y1);
            r.w = COORD_W'(x2 - x1);
            r.h = COORD_W'(y2 - y1);
        end
        return r;
    endfunction

    function automatic longint box_area(t_box b);
        return longint'(b.w) * longint'(b.h);
    endfunction

    // one input word through the predicted table; returns the result word
    function automatic t_result cluster_step(logic op, t_box b);
        t_result r;
        longint  ov_a, n;
        int      slot;
        r = '0;
        if (op == OP_CLEAR) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                slot_used[k] = 0;
                slot_cnt[k]  = 0;
            end
            return r;
        end
        slot = -1;
        // first fit in creation order
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (slot < 0 && slot_used[k]) begin
                ov_a = box_area(box_meet(slot_meet[k], b)) * 256;
                if (ov_a >= longint'(cap_cur) * box_area(slot_meet[k]) ||
                    ov_a >= longint'(cap_cur) * box_area(b))
                    slot = k;
            end
        end
        if (slot >= 0) begin
            n = slot_cnt[slot];
            slot_meet[slot]  = box_meet(slot_meet[slot], b);
            slot_avg[slot].x = COORD_W'((longint'(slot_avg[slot].x) * n + b.x) / (n + 1));
            slot_avg[slot].y = COORD_W'((longint'(slot_avg[slot].y) * n + b.y) / (n + 1));
            slot_avg[slot].w = COORD_W'((longint'(slot_avg[slot].w) * n + b.w) / (n + 1));
            slot_avg[slot].h = COORD_W'((longint'(slot_avg[slot].h) * n + b.h) / (n + 1));
            if (slot_cnt[slot] < 65535)
                slot_cnt[slot]++;
        end else begin
            for (int k = 0; k < NUM_SLOTS; k++)
                if (slot < 0 && !slot_used[k])
                    slot = k;
            if (slot < 0) begin
                r.dropped = 1'b1;     // table full
                return r;
            end
            slot_used[slot] = 1;
            slot_meet[slot] = b;
            slot_avg[slot]  = b;
            slot_cnt[slot]  = 1;
            r.created       = 1'b1;
        end
        r.cluster_index = slot[3:0];
        r.member_count  = slot_cnt[slot][15:0];
        r.mean          = slot_avg[slot];
        return r;
    endfunction

    // receiver: random idling plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // result checker, compares each accepted word with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                want = pending_words.pop_front();
                check_field("cluster_index", want.cluster_index, o_cluster_index);
                check_field("created", want.created, o_created);
                check_field("dropped", want.dropped, o_dropped);
                check_field("member_count", want.member_count, o_member_count);
                check_field("mean_x", want.mean.x, o_mean_x);
                check_field("mean_y", want.mean.y, o_mean_y);
                check_field("mean_w", want.mean.w, o_mean_w);
                check_field("mean_h", want.mean.h, o_mean_h);
            end
        end
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // offer one word; valid stays high across back-to-back words
    task automatic send_box(logic op, int x, int y, int w, int h);
        t_box    b;
        t_result exp_word;
        @(negedge i_clk);
        if ($urandom_range(99) < tx_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        b = {x[11:0], y[11:0], w[11:0], h[11:0]};
        i_operation <= op;
        i_box_x     <= b.x;
        i_box_y     <= b.y;
        i_box_w     <= b.w;
        i_box_h     <= b.h;
        i_in_valid  <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        exp_word = cluster_step(op, b);
        pending_words = {pending_words, exp_word};
    endtask

    // drop valid and let the block drain completely
    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_cap(int unsigned val);
        @(negedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= REG_CAP;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        cap_cur = val & 32'h1FF;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly boxes jittered around a few anchors so clusters grow;
    // some full-range noise, zero sizes and clears
    task automatic random_item;
        int pick, anchor, ax, ay;
        pick = $urandom_range(99);
        if (pick < 4) begin
            send_box(OP_CLEAR, $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(4095), $urandom_range(4095));
        end else if (pick < 14) begin
            send_box(OP_ADD, $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(4095), $urandom_range(4095));
        end else begin
            anchor = $urandom_range(7);
            ax = (anchor * 523) % 3700;
            ay = (anchor * 911) % 3700;
            send_box(OP_ADD, ax + $urandom_range(40), ay + $urandom_range(40),
                     (pick < 17) ? 0 : 40 + $urandom_range(160),
                     (pick > 97) ? 0 : 40 + $urandom_range(160));
        end
    endtask

    task automatic test_extremes;
        send_box(OP_CLEAR, 0, 0, 0, 0);
        send_box(OP_ADD, 0, 0, 0, 0);               // empty cluster opened
        send_box(OP_ADD, 4095, 4095, 4095, 4095);   // empty intersection takes all
        send_box(OP_CLEAR, 4095, 4095, 4095, 4095);
        send_box(OP_ADD, 0, 0, 4095, 4095);
        send_box(OP_ADD, 100, 100, 0, 50);          // zero-sized box joins
        send_box(OP_ADD, 4095, 4095, 4095, 4095);   // empty running intersection: joins
        send_box(OP_ADD, 10, 10, 20, 20);
        drain();
    endtask

    task automatic test_table_full;
        write_cap(256);
        send_box(OP_CLEAR, 0, 0, 0, 0);
        for (int k = 0; k <= NUM_SLOTS; k++)
            send_box(OP_ADD, k * 200, 50, 100, 100);   // last one is dropped
        send_box(OP_ADD, 15 * 200, 50, 100, 100);
        drain();
    endtask

    task automatic test_cap_edges;
        write_cap(300);                             // only zero areas pass
        send_box(OP_ADD, 0, 50, 100, 100);
        send_box(OP_ADD, 20, 60, 0, 10);
        drain();
        write_cap(0);                               // everything joins
        send_box(OP_ADD, 3000, 3000, 500, 500);
        drain();
    endtask

    task automatic test_random(int count, int tx_pct, int rx_pct, int unsigned cap);
        tx_gap_pct  = tx_pct;
        rx_idle_pct = rx_pct;
        write_cap(cap);
        for (int i = 0; i < count; i++)
            random_item();
        drain();
    endtask

    // receiver holds off while words keep coming, so the input must stall
    task automatic test_backpressure;
        tx_gap_pct  = 0;
        rx_idle_pct = 0;
        @(posedge i_clk);
        hold_req = 1'b1;
        for (int i = 0; i < 25; i++)
            random_item();
        drain();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_operation = OP_ADD;
        i_box_x = '0; i_box_y = '0; i_box_w = '0; i_box_h = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        tx_gap_pct  = 28;
        rx_idle_pct = 78;
        cap_cur     = CAP_RESET;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            slot_used[k] = 0;
            slot_cnt[k]  = 0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_table_full();
        test_cap_edges();
        test_random(140, 28, 78, 128);
        test_random(140, 78, 28, 200);
        test_random(60, 0, 0, 511);
        test_random(60, 0, 0, 64);
        test_backpressure();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
